FILE: rtl/pcni_pkg.sv
// ----------------------------------------------------------------------------
// pcni_pkg
// shared types, constants and the neighbour slot step table
// ----------------------------------------------------------------------------
package pcni_pkg;

	localparam int IDX_W   = 24;
	localparam int COORD_W = 8;
	localparam int COUNT_W = 9;
	localparam int AREA_W  = 18;
	localparam int SLOT_W  = 5;

	localparam logic [SLOT_W-1:0] FIRST_SLOT = 5'd0;
	localparam logic [SLOT_W-1:0] LAST_SLOT  = 5'd25;

	localparam logic [1:0] CFG_CELLS_X = 2'd0;
	localparam logic [1:0] CFG_CELLS_Y = 2'd1;
	localparam logic [1:0] CFG_CELLS_Z = 2'd2;

	typedef enum logic [1:0] {
		STEP_HOLD,
		STEP_UP,
		STEP_DOWN
	} step_t;

	typedef struct packed {
		step_t dx;
		step_t dy;
		step_t dz;
	} step3_t;

	typedef struct packed {
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic [COORD_W-1:0] cell_z;
	} cell_beat_t;

	typedef struct packed {
		logic [IDX_W-1:0]  home_index;
		logic [SLOT_W-1:0] slot;
		logic [IDX_W-1:0]  neighbour_index;
		logic              last;
		logic              range_error;
	} nbr_beat_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [SLOT_W-1:0]  slot;
		logic               last;
		logic               err;
	} slot_beat_t;

	typedef struct packed {
		logic [COORD_W-1:0] hx;
		logic [COORD_W-1:0] hy;
		logic [COORD_W-1:0] hz;
		logic [COUNT_W-1:0] qx;
		logic [COUNT_W-1:0] qy;
		logic [COUNT_W-1:0] qz;
		logic [SLOT_W-1:0]  slot;
		logic               last;
		logic               err;
	} wrap_beat_t;

	typedef struct packed {
		logic [COORD_W-1:0] hx;
		logic [IDX_W-1:0]   h_yterm;
		logic [IDX_W-1:0]   h_zterm;
		logic [COUNT_W-1:0] qx;
		logic [IDX_W-1:0]   n_yterm;
		logic [IDX_W-1:0]   n_zterm;
		logic [SLOT_W-1:0]  slot;
		logic               last;
		logic               err;
	} prod_beat_t;

	function automatic step3_t slot_step(input logic [SLOT_W-1:0] slot);
		step3_t s;
		case (slot)
			5'd0:    s = '{STEP_UP,   STEP_HOLD, STEP_HOLD};
			5'd1:    s = '{STEP_UP,   STEP_UP,   STEP_HOLD};
			5'd2:    s = '{STEP_HOLD, STEP_UP,   STEP_HOLD};
			5'd3:    s = '{STEP_DOWN, STEP_UP,   STEP_HOLD};
			5'd4:    s = '{STEP_UP,   STEP_HOLD, STEP_DOWN};
			5'd5:    s = '{STEP_UP,   STEP_UP,   STEP_DOWN};
			5'd6:    s = '{STEP_HOLD, STEP_UP,   STEP_DOWN};
			5'd7:    s = '{STEP_DOWN, STEP_UP,   STEP_DOWN};
			5'd8:    s = '{STEP_UP,   STEP_HOLD, STEP_UP};
			5'd9:    s = '{STEP_UP,   STEP_UP,   STEP_UP};
			5'd10:   s = '{STEP_HOLD, STEP_UP,   STEP_UP};
			5'd11:   s = '{STEP_DOWN, STEP_UP,   STEP_UP};
			5'd12:   s = '{STEP_HOLD, STEP_HOLD, STEP_UP};
			5'd13:   s = '{STEP_DOWN, STEP_HOLD, STEP_HOLD};
			5'd14:   s = '{STEP_HOLD, STEP_DOWN, STEP_HOLD};
			5'd15:   s = '{STEP_HOLD, STEP_HOLD, STEP_DOWN};
			5'd16:   s = '{STEP_UP,   STEP_DOWN, STEP_HOLD};
			5'd17:   s = '{STEP_DOWN, STEP_DOWN, STEP_HOLD};
			5'd18:   s = '{STEP_DOWN, STEP_HOLD, STEP_UP};
			5'd19:   s = '{STEP_DOWN, STEP_HOLD, STEP_DOWN};
			5'd20:   s = '{STEP_HOLD, STEP_DOWN, STEP_UP};
			5'd21:   s = '{STEP_HOLD, STEP_DOWN, STEP_DOWN};
			5'd22:   s = '{STEP_UP,   STEP_DOWN, STEP_UP};
			5'd23:   s = '{STEP_UP,   STEP_DOWN, STEP_DOWN};
			5'd24:   s = '{STEP_DOWN, STEP_DOWN, STEP_UP};
			5'd25:   s = '{STEP_DOWN, STEP_DOWN, STEP_DOWN};
			default: s = '{STEP_HOLD, STEP_HOLD, STEP_HOLD};
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/pcni_seq.sv
// ----------------------------------------------------------------------------
// pcni_seq
// holds one home cell and issues its neighbour slots, one beat per cycle while sb_ready is high
// ----------------------------------------------------------------------------
module pcni_seq import pcni_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cell_valid,
	output logic               cell_ready,
	input  cell_beat_t         coord,
	input  logic [COUNT_W-1:0] nx,
	input  logic [COUNT_W-1:0] ny,
	input  logic [COUNT_W-1:0] nz,
	output logic               sb_valid,
	input  logic               sb_ready,
	output slot_beat_t         sb
);

	logic               busy_q;
	logic               err_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [COORD_W-1:0] z_q;
	logic               last;
	logic               issue;
	logic               accept;
	logic               out_of_range;

	assign last         = err_q || (slot_q == LAST_SLOT);
	assign issue        = busy_q && sb_ready;
	assign cell_ready   = !busy_q || (issue && last);
	assign accept       = cell_valid && cell_ready;
	assign out_of_range = ({1'b0, coord.cell_x} >= nx) || ({1'b0, coord.cell_y} >= ny) ||
		({1'b0, coord.cell_z} >= nz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			err_q  <= 1'b0;
			slot_q <= FIRST_SLOT;
		end else if (accept) begin
			busy_q <= 1'b1;
			err_q  <= out_of_range;
			slot_q <= FIRST_SLOT;
		end else if (issue) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				slot_q <= slot_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= coord.cell_x;
			y_q <= coord.cell_y;
			z_q <= coord.cell_z;
		end
	end

	assign sb_valid = busy_q;
	assign sb       = '{x: x_q, y: y_q, z: z_q, slot: slot_q, last: last, err: err_q};

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> slot_q <= LAST_SLOT)
		else $error("slot counter past last slot");

	a_slot_advance: assert property (@(posedge clk) disable iff (!arst_n)
		issue && !last && !accept |=> busy_q && slot_q == $past(slot_q) + 5'd1)
		else $error("slot counter did not advance on an issued beat");

endmodule

FILE: rtl/pcni_wrap.sv
// ----------------------------------------------------------------------------
// pcni_wrap
// first stage: periodic wrap of the neighbour coordinates per axis
// ----------------------------------------------------------------------------
module pcni_wrap import pcni_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [COUNT_W-1:0] nx,
	input  logic [COUNT_W-1:0] ny,
	input  logic [COUNT_W-1:0] nz,
	input  logic               sb_valid,
	output logic               sb_ready,
	input  slot_beat_t         sb,
	output logic               wb_valid,
	input  logic               wb_ready,
	output wrap_beat_t         wb
);

	function automatic logic [COUNT_W-1:0] wrap_axis(input logic [COORD_W-1:0] c,
		input logic [COUNT_W-1:0] n, input step_t d);
		logic [COUNT_W-1:0] up;
		logic [COUNT_W-1:0] r;
		up = {1'b0, c} + 9'd1;
		case (d)
			STEP_UP:   r = (up >= n) ? '0 : up;
			STEP_DOWN: r = (c == '0) ? n - 9'd1 : {1'b0, c} - 9'd1;
			default:   r = {1'b0, c};
		endcase
		return r;
	endfunction

	logic       v_s1;
	wrap_beat_t beat_s1;
	step3_t     st;

	assign st       = slot_step(sb.slot);
	assign sb_ready = !v_s1 || wb_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (sb_ready) begin
			v_s1 <= sb_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sb_ready && sb_valid) begin
			beat_s1.hx   <= sb.x;
			beat_s1.hy   <= sb.y;
			beat_s1.hz   <= sb.z;
			beat_s1.qx   <= wrap_axis(sb.x, nx, st.dx);
			beat_s1.qy   <= wrap_axis(sb.y, ny, st.dy);
			beat_s1.qz   <= wrap_axis(sb.z, nz, st.dz);
			beat_s1.slot <= sb.slot;
			beat_s1.last <= sb.last;
			beat_s1.err  <= sb.err;
		end
	end

	assign wb_valid = v_s1;
	assign wb       = beat_s1;

endmodule

FILE: rtl/pcni_index.sv
// ----------------------------------------------------------------------------
// pcni_index
// second and third stages: row and plane products, then the linear sums
// ----------------------------------------------------------------------------
module pcni_index import pcni_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [COUNT_W-1:0] nx,
	input  logic [AREA_W-1:0]  area,
	input  logic               wb_valid,
	output logic               wb_ready,
	input  wrap_beat_t         wb,
	output logic               nbr_valid,
	input  logic               nbr_ready,
	output nbr_beat_t          nbr
);

	logic       v_s2;
	logic       v_s3;
	prod_beat_t beat_s2;
	nbr_beat_t  beat_s3;
	logic       ready_s2;
	logic       ready_s3;

	logic [17:0] h_y_p;
	logic [25:0] h_z_p;
	logic [17:0] n_y_p;
	logic [26:0] n_z_p;
	logic [IDX_W-1:0] home_sum;
	logic [IDX_W-1:0] nbr_sum;

	assign h_y_p = {10'b0, wb.hy} * {9'b0, nx};
	assign h_z_p = {18'b0, wb.hz} * {8'b0, area};
	assign n_y_p = {9'b0, wb.qy} * {9'b0, nx};
	assign n_z_p = {18'b0, wb.qz} * {9'b0, area};

	assign ready_s3 = !v_s3 || nbr_ready;
	assign ready_s2 = !v_s2 || ready_s3;
	assign wb_ready = ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				v_s2 <= wb_valid;
			end
			if (ready_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && wb_valid) begin
			beat_s2.hx      <= wb.hx;
			beat_s2.h_yterm <= {6'b0, h_y_p};
			beat_s2.h_zterm <= h_z_p[IDX_W-1:0];
			beat_s2.qx      <= wb.qx;
			beat_s2.n_yterm <= {6'b0, n_y_p};
			beat_s2.n_zterm <= n_z_p[IDX_W-1:0];
			beat_s2.slot    <= wb.slot;
			beat_s2.last    <= wb.last;
			beat_s2.err     <= wb.err;
		end
	end

	assign home_sum = {16'b0, beat_s2.hx} + beat_s2.h_yterm + beat_s2.h_zterm;
	assign nbr_sum  = {15'b0, beat_s2.qx} + beat_s2.n_yterm + beat_s2.n_zterm;

	always_ff @(posedge clk) begin
		if (ready_s3 && v_s2) begin
			// rejected cell: single beat with zero indices
			if (beat_s2.err) begin
				beat_s3 <= '{home_index: '0, slot: FIRST_SLOT, neighbour_index: '0,
					last: 1'b1, range_error: 1'b1};
			end else begin
				beat_s3 <= '{home_index: home_sum, slot: beat_s2.slot,
					neighbour_index: nbr_sum, last: beat_s2.last, range_error: 1'b0};
			end
		end
	end

	assign nbr_valid = v_s3;
	assign nbr       = beat_s3;

endmodule

FILE: rtl/periodic_cell_neighbour_index.sv
// ----------------------------------------------------------------------------
// periodic_cell_neighbour_index
// 26-neighbour linear index generator for a periodic 3-D link-cell grid
// ----------------------------------------------------------------------------
// The cell channel takes one home cell coordinate per beat. For each one the
// nbr channel gives 26 beats, slots 0 to 25 in the fixed order, each with the
// home and wrapped neighbour linear index, x fastest; last marks slot 25.
// A coordinate at or above its axis count gives one beat with range_error and
// last set and all indices zero.
// The cfg channel writes cells_x, cells_y, cells_z (index 0, 1, 2; other
// indices are dropped) and is always ready; the user must write it only
// while idle, which the block does not enforce. Counts above AXIS_MAX
// saturate to AXIS_MAX. Throughput: one nbr beat per cycle while nbr_ready
// allows, set by the slot sequencer; the next cell is accepted on the edge
// that issues the last slot of the current one.
// After a cell beat is accepted, its first nbr beat passes in turn through
// the registered wrap, products and sums stages.
// Reset clears the pipeline and sets every axis count to 1. A stalled nbr
// beat holds the pipeline without loss; stages behind it keep filling.
// ----------------------------------------------------------------------------
module periodic_cell_neighbour_index import pcni_pkg::*; #(
	parameter int AXIS_MAX = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cell_valid,
	output logic               cell_ready,
	input  cell_beat_t         coord,
	output logic               nbr_valid,
	input  logic               nbr_ready,
	output nbr_beat_t          nbr,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [COUNT_W-1:0] cfg_data
);

	function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] c);
		logic [COUNT_W-1:0] r;
		if (int'(c) > AXIS_MAX) begin
			r = COUNT_W'(AXIS_MAX);
		end else begin
			r = c;
		end
		return r;
	endfunction

	logic [COUNT_W-1:0] cells_x_q;
	logic [COUNT_W-1:0] cells_y_q;
	logic [COUNT_W-1:0] cells_z_q;
	logic [AREA_W-1:0]  area_q;
	logic [COUNT_W-1:0] nx;
	logic [COUNT_W-1:0] ny;
	logic [COUNT_W-1:0] nz;

	logic       sb_valid;
	logic       sb_ready;
	slot_beat_t sb;
	logic       wb_valid;
	logic       wb_ready;
	wrap_beat_t wb;

	assign cfg_ready = 1'b1;
	assign nx = sat_count(cells_x_q);
	assign ny = sat_count(cells_y_q);
	assign nz = sat_count(cells_z_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= 9'd1;
			cells_y_q <= 9'd1;
			cells_z_q <= 9'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CELLS_X: cells_x_q <= cfg_data;
				CFG_CELLS_Y: cells_y_q <= cfg_data;
				CFG_CELLS_Z: cells_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// plane size, registered; it settles in the cycle after a count write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q <= 18'd1;
		end else begin
			area_q <= {9'b0, nx} * {9'b0, ny};
		end
	end

	pcni_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.coord      (coord),
		.nx         (nx),
		.ny         (ny),
		.nz         (nz),
		.sb_valid   (sb_valid),
		.sb_ready   (sb_ready),
		.sb         (sb)
	);

	pcni_wrap u_wrap (
		.clk      (clk),
		.arst_n   (arst_n),
		.nx       (nx),
		.ny       (ny),
		.nz       (nz),
		.sb_valid (sb_valid),
		.sb_ready (sb_ready),
		.sb       (sb),
		.wb_valid (wb_valid),
		.wb_ready (wb_ready),
		.wb       (wb)
	);

	pcni_index u_index (
		.clk       (clk),
		.arst_n    (arst_n),
		.nx        (nx),
		.area      (area_q),
		.wb_valid  (wb_valid),
		.wb_ready  (wb_ready),
		.wb        (wb),
		.nbr_valid (nbr_valid),
		.nbr_ready (nbr_ready),
		.nbr       (nbr)
	);

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		nbr_valid && nbr.range_error |-> nbr.last && nbr.slot == FIRST_SLOT &&
		nbr.home_index == '0 && nbr.neighbour_index == '0)
		else $error("range error beat not a lone zero beat");

	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		nbr_valid && !nbr.range_error |-> nbr.last == (nbr.slot == LAST_SLOT))
		else $error("last flag does not match final slot");

endmodule
